// ----- sv/whs_pkg.sv -----
// ----------------------------------------------------------------------------
// whs_pkg
// Shared types, sizes and helpers for the wavelength horizon scheduler.
// ----------------------------------------------------------------------------
package whs_pkg;

  localparam int NumPorts    = 8;
  localparam int MaxChannels = 32;
  localparam int CmdW        = 2;
  localparam int PortW       = 4;
  localparam int ChanW       = 5;
  localparam int CntW        = 6;
  localparam int TimeW       = 63;
  localparam int CfgW        = 48;
  localparam int Depth       = (NumPorts + 1) * MaxChannels;
  localparam int AddrW       = $clog2(Depth);

  typedef enum logic [CmdW-1:0] {
    CmdFind   = 2'd0,
    CmdUpdate = 2'd1,
    CmdQuery  = 2'd2
  } cmd_e;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StScan  = 6'b000100,
    StDrain = 6'b001000,
    StQuery = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  // channel count of a port; loopback port has one channel
  function automatic logic [CntW-1:0] count_of(input logic [CfgW-1:0]  counts,
                                               input logic [PortW-1:0] port);
    logic [CntW-1:0] c;
    c = '0;
    if (int'(port) == NumPorts) begin
      c = CntW'(1);
    end else begin
      for (int k = 0; k < NumPorts; k++) begin
        if (int'(port) == k) begin
          c = counts[k*CntW +: CntW];
        end
      end
      if (int'(c) > MaxChannels) begin
        c = CntW'(MaxChannels);
      end
    end
    return c;
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic [PortW-1:0] port,
                                               input logic [ChanW-1:0] chan);
    return AddrW'(int'(port) * MaxChannels + int'(chan));
  endfunction

endpackage

// ----- sv/wavelength_horizon_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// wavelength_horizon_scheduler_core
// Per-channel horizon table with nearest-channel search, update and query.
// ----------------------------------------------------------------------------
// The horizons live in one single-port-read, single-port-write RAM of
// (ports+1) x 32 entries. After reset the block sweeps the RAM to zero,
// one entry per cycle, and takes no item meanwhile; the channel-count
// register can be written at any time. An update, an error, an unused
// command and a find on a port with no channels go straight to the done
// state; a query reads its horizon in a query state first, and a find
// reads the port's channels one horizon per cycle, then checks the last
// in a drain state. One item is processed at a time; a new item is taken
// while the previous result still sits in the output register.
module wavelength_horizon_scheduler_core
  import whs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [PortW-1:0]  port_i,
  input  logic [ChanW-1:0]  channel_i,
  input  logic [TimeW-1:0]  time_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [ChanW-1:0]  chosen_channel_o,
  output logic [TimeW-1:0]  horizon_value_o,
  output logic [CntW-1:0]   port_channels_o,
  output logic              range_error_o
);

  state_e state_q, state_d;

  logic [CfgW-1:0]  counts_q;
  logic [AddrW-1:0] clr_idx_q;
  logic [ChanW-1:0] idx_q;
  logic [ChanW-1:0] pend_ch_q;
  logic             pend_q;
  logic             out_valid_q;

  logic [PortW-1:0] port_q;
  logic [TimeW-1:0] time_q;
  logic [CntW-1:0]  cnt_q;
  logic             err_q;
  logic             found_q;
  logic [ChanW-1:0] chosen_q;
  logic [TimeW-1:0] best_q;
  logic [TimeW-1:0] hval_q;

  logic [TimeW-1:0] mem [Depth];
  logic [TimeW-1:0] mem_rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [TimeW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  logic             accept;
  logic [CntW-1:0]  in_cnt;
  logic             port_bad;
  logic             ch_bad;
  logic             scan_last;
  logic             hit;
  logic             out_load;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign in_cnt    = count_of(counts_q, port_i);
  assign port_bad  = (int'(port_i) > NumPorts);
  assign ch_bad    = ({1'b0, channel_i} >= in_cnt);
  assign scan_last = ({1'b0, idx_q} == (cnt_q - CntW'(1)));
  assign hit       = pend_q && (time_q > mem_rdata_q) &&
                     (!found_q || (mem_rdata_q > best_q));
  assign out_load  = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(port_i, channel_i);
    mem_wdata = time_value_i;
    mem_raddr = addr_of(port_q, idx_q);
    if (state_q == StClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else if (accept) begin
      mem_raddr = addr_of(port_i, channel_i);
      mem_we    = (cmd_i == CmdUpdate) && !port_bad && !ch_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (int'(clr_idx_q) == Depth - 1) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          if (cmd_i == CmdFind && !port_bad && in_cnt != '0) begin
            state_d = StScan;
          end else if (cmd_i == CmdQuery && !port_bad && !ch_bad) begin
            state_d = StQuery;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScan: begin
        if (scan_last) state_d = StDrain;
      end
      StDrain: state_d = StDone;
      StQuery: state_d = StDone;
      StDone: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      counts_q    <= '0;
      clr_idx_q   <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_ch_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) counts_q <= cfg_wdata_i;
      if (state_q == StClear) clr_idx_q <= clr_idx_q + AddrW'(1);
      if (accept) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
      end else if (state_q == StScan) begin
        idx_q     <= idx_q + ChanW'(1);
        pend_q    <= 1'b1;
        pend_ch_q <= idx_q;
      end else begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      port_q   <= port_i;
      time_q   <= time_value_i;
      found_q  <= 1'b0;
      chosen_q <= '0;
      best_q   <= '0;
      hval_q   <= '0;
      priority if (cmd_i != CmdFind && cmd_i != CmdUpdate && cmd_i != CmdQuery) begin
        cnt_q <= '0;
        err_q <= 1'b1;
      end else if (port_bad) begin
        cnt_q <= in_cnt;
        err_q <= 1'b1;
      end else begin
        cnt_q <= in_cnt;
        err_q <= (cmd_i != CmdFind) && ch_bad;
      end
    end else begin
      if (hit) begin
        found_q  <= 1'b1;
        best_q   <= mem_rdata_q;
        chosen_q <= pend_ch_q;
      end
      if (state_q == StQuery) hval_q <= mem_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_o          <= found_q;
      chosen_channel_o <= chosen_q;
      horizon_value_o  <= hval_q;
      port_channels_o  <= cnt_q;
      range_error_o    <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
